// ===== rtl/core/cbfp_pkg.sv =====
// Shared constants and types of the camera block frame parser.
package cbfp_pkg;

  localparam logic [7:0] SYNC_LO   = 8'h55;
  localparam logic [7:0] SYNC_HI   = 8'h56;
  localparam logic [7:0] SYNC_TAIL = 8'hAA;
  localparam logic [7:0] FRAME_TAG = 8'h00;

  localparam int unsigned MSG_LEN = 14;
  localparam int unsigned PosW    = 4;

  localparam logic [PosW-1:0] POS_HUNT  = 4'd0;
  localparam logic [PosW-1:0] POS_SYNC  = 4'd1;
  localparam logic [PosW-1:0] POS_BODY  = 4'd2;
  localparam logic [PosW-1:0] POS_CHK   = 4'd3;
  localparam logic [PosW-1:0] POS_LAST  = 4'd13;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] signature;
    logic [15:0] obj_x;
    logic [15:0] obj_y;
    logic [15:0] obj_width;
    logic [15:0] obj_height;
  } result_t;

  function automatic logic is_sync(input logic [7:0] b);
    return (b == SYNC_LO) || (b == SYNC_HI);
  endfunction

endpackage

// ===== rtl/core/cbfp_if.sv =====
// Handshake channel interfaces for received bytes and parsed results.
interface cbfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cbfp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] signature;
  logic [15:0] obj_x;
  logic [15:0] obj_y;
  logic [15:0] obj_width;
  logic [15:0] obj_height;

  modport source (output valid, output kind, output signature, output obj_x,
                  output obj_y, output obj_width, output obj_height, input ready);
  modport sink   (input valid, input kind, input signature, input obj_x,
                  input obj_y, input obj_width, input obj_height, output ready);
endinterface

// ===== rtl/core/camera_block_frame_parser_core.sv =====
// Top level of the camera block frame parser.
//
// Channel  Direction  Payload
// rx_i     in         rx_byte
// res_o    out        kind, signature, obj_x, obj_y, obj_width, obj_height
//
// One byte is accepted per cycle while the result register can take a result; its result, if any,
// passes from the input register through the decode into the result register.
// Reset clears the byte position to hunting and empties both registers.
// A stalled result holds the decode; bytes keep arriving until the input register fills.
module camera_block_frame_parser_core import cbfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  cbfp_byte_if.sink     rx_i,
  cbfp_result_if.source res_o
);

  logic       in_valid, out_free, step, res_valid;
  logic [7:0] in_byte;
  result_t    res, res_q;

  assign step = in_valid && out_free;

  cbfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .byte_i  (rx_i.rx_byte),
    .take_i  (step),
    .ready_o (rx_i.ready),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  cbfp_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cbfp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .valid_i (res_valid),
    .res_i   (res),
    .ready_i (res_o.ready),
    .free_o  (out_free),
    .valid_o (res_o.valid),
    .res_o   (res_q)
  );

  assign res_o.kind       = res_q.kind;
  assign res_o.signature  = res_q.signature;
  assign res_o.obj_x      = res_q.obj_x;
  assign res_o.obj_y      = res_q.obj_y;
  assign res_o.obj_width  = res_q.obj_width;
  assign res_o.obj_height = res_q.obj_height;

endmodule

// ===== rtl/core/cbfp_in_stage.sv =====
// Input register that holds one received byte until the parser takes it.
module cbfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_q && !take_i) || (valid_i && ready_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/cbfp_decode.sv =====
// Byte position tracker, message store and result decode of the parser.
module cbfp_decode import cbfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [PosW-1:0] pos_q, pos_d, pos;
  logic [7:0]      store_q [POS_BODY:POS_LAST-1];

  always_comb begin
    pos         = (pos_q >= PosW'(MSG_LEN)) ? POS_HUNT : pos_q;
    pos_d       = pos;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (pos == POS_HUNT) begin
      pos_d = is_sync(byte_i) ? POS_SYNC : POS_HUNT;
    end else if (pos == POS_SYNC) begin
      if (byte_i == FRAME_TAG) begin
        pos_d       = POS_HUNT;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_FRAME;
      end else if (byte_i == SYNC_TAIL) begin
        pos_d = POS_BODY;
      end else begin
        pos_d = POS_HUNT;
      end
    end else if (pos == POS_CHK && is_sync(store_q[POS_BODY]) && byte_i == SYNC_TAIL) begin
      pos_d       = POS_BODY;
      res_valid_o = 1'b1;
      res_o.kind  = KIND_FRAME;
    end else if (pos == POS_LAST) begin
      pos_d            = POS_HUNT;
      res_valid_o      = 1'b1;
      res_o.kind       = KIND_BLOCK;
      res_o.signature  = {store_q[5], store_q[4]};
      res_o.obj_x      = {store_q[7], store_q[6]};
      res_o.obj_y      = {store_q[9], store_q[8]};
      res_o.obj_width  = {store_q[11], store_q[10]};
      res_o.obj_height = {byte_i, store_q[12]};
    end else begin
      pos_d = pos + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HUNT;
    end else if (step_i) begin
      pos_q <= pos_d;
    end
  end

  for (genvar i = POS_BODY; i < POS_LAST; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (step_i && pos == PosW'(i)) begin
        store_q[i] <= byte_i;
      end
    end
  end

endmodule

// ===== rtl/core/cbfp_out_stage.sv =====
// Result register that holds one parsed item until the consumer takes it.
module cbfp_out_stage import cbfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    valid_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? valid_i : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
